// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_RST(label, prop)
`endif
`endif

// ----- hw/rtl/pcmsg_pkg.sv -----
package pcmsg_pkg;

  localparam int MemAddrBits  = 19;
  localparam int FractionBits = 12;
  localparam int MemDepth     = 1 << MemAddrBits;
  localparam int RegCount     = 16;
  localparam int ScaleBits    = 26;
  localparam int PosBits      = 31;
  localparam int DivSteps     = ScaleBits;
  localparam int Recip15      = 559241;
  localparam int Recip15Shift = 15;

  localparam logic [3:0] RegVolume = 4'hC;
  localparam logic [3:0] RegLoop   = 4'hD;
  localparam logic [7:0] RegKey0   = 8'd5;
  localparam logic [7:0] RegKey1   = 8'd11;
  localparam logic [7:0] RegChan1  = 8'd6;
  localparam logic [7:0] RegPerCh  = 8'd12;

  localparam logic [3:0] RegPitchLo = 4'd0;
  localparam logic [3:0] RegPitchHi = 4'd1;
  localparam logic [3:0] RegStart0  = 4'd2;
  localparam logic [3:0] RegStart1  = 4'd3;
  localparam logic [3:0] RegStart2  = 4'd4;
  localparam logic [3:0] RegKeyOff  = 4'd5;

  localparam logic CfgStepScale = 1'b0;
  localparam logic CfgMuteMask  = 1'b1;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_BANK  = 3'd3,
    CMD_LOAD  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_T_ADDR,
    ST_T_NEXT,
    ST_T_MUL,
    ST_T_ACC,
    ST_OUT
  } state_t;

endpackage

// ----- hw/rtl/pcmsg_if.sv -----
interface pcmsg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  reg_address;
  logic [7:0]  data;
  logic [18:0] mem_address;
  logic        channel;
  logic [1:0]  bank;
  modport source (output valid, cmd, reg_address, data, mem_address, channel, bank,
                  input ready);
  modport sink (input valid, cmd, reg_address, data, mem_address, channel, bank,
                output ready);
endinterface

interface pcmsg_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         read_data;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [1:0]         playing;
  modport source (output valid, read_data, left_sample, right_sample, playing,
                  input ready);
  modport sink (input valid, read_data, left_sample, right_sample, playing,
                output ready);
endinterface

// ----- hw/rtl/two_channel_pcm_sound_generator.sv -----
// Channel   Direction  Transfer
// in_ch     sink       one command: write, read, tick, bank or sample load
// out_ch    source     one result for every command
// cfg_*     write      step_scale (index 0), mute_mask (index 1)
// A command that needs no division or memory walk goes from idle to the output state, which registers its result.
// A pitch write runs the divider, one quotient bit per cycle, before its result is given.
// A tick visits both channels in turn; a playing channel is paced by the single read port.
// Reset is synchronous; no clearing pass runs, sample memory is not cleared.
// A stalled result holds the next result in the output state; no command is taken then.
`include "assert_macros.svh"

module two_channel_pcm_sound_generator
  import pcmsg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  pcmsg_in_if.sink             in_ch,
  pcmsg_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [ScaleBits-1:0] cfg_wdata
);

  typedef logic [MemAddrBits-1:0] maddr_t;

  state_t                state_r, state_nxt;
  logic                  ch_r, ch_nxt;
  logic [7:0]            regs_r [RegCount];
  logic [7:0]            regs_nxt [RegCount];
  logic [ScaleBits-1:0]  inc_r [2];
  logic [ScaleBits-1:0]  inc_nxt [2];
  logic [PosBits-1:0]    pos_r [2];
  logic [PosBits-1:0]    pos_nxt [2];
  maddr_t                start_r [2];
  maddr_t                start_nxt [2];
  logic [1:0]            act_r, act_nxt;
  logic [1:0]            bank_r [2];
  logic [1:0]            bank_nxt [2];
  logic [ScaleBits-1:0]  scale_r;
  logic [1:0]            mute_r;

  logic [7:0]            b0_r, b0_nxt;
  logic [10:0]           prod_r, prod_nxt;
  logic                  neg_r, neg_nxt;
  logic                  end_r, end_nxt;
  logic signed [15:0]    acc_r, acc_nxt;
  logic [7:0]            rd_r, rd_nxt;

  logic [ScaleBits-1:0]  dvd_r, dvd_nxt;
  logic [8:0]            rem_r, rem_nxt;
  logic [9:0]            divisor_r, divisor_nxt;
  logic [4:0]            cnt_r, cnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_rd_r, out_rd_nxt;
  logic signed [15:0]    out_smp_r, out_smp_nxt;
  logic [1:0]            out_play_r, out_play_nxt;

  logic [7:0]            mem [MemDepth];
  logic [7:0]            mem_q;
  logic                  mem_we;
  maddr_t                mem_raddr;
  maddr_t                cur_addr;

  function automatic maddr_t start_calc(input logic [7:0] s0, input logic [7:0] s1,
                                        input logic [7:0] s2, input logic [1:0] bk);
    logic [16:0] off;
    off = {s2[0], s1, s0};
    return MemAddrBits'({bk, 17'd0}) + MemAddrBits'(off);
  endfunction

  function automatic logic [3:0] ch_base(input logic c);
    return c ? RegChan1[3:0] : 4'd0;
  endfunction

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_rd_r;
  assign out_ch.left_sample  = out_smp_r;
  assign out_ch.right_sample = out_smp_r;
  assign out_ch.playing      = out_play_r;

  assign cur_addr  = start_r[ch_r] + MemAddrBits'(pos_r[ch_r] >> FractionBits);
  assign mem_raddr = (state_r == ST_T_NEXT) ? cur_addr + maddr_t'(1) : cur_addr;
  assign mem_we    = in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_LOAD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_ch.mem_address[MemAddrBits-1:0]] <= in_ch.data;
    end
    mem_q <= mem[mem_raddr];
  end

  always_comb begin
    logic [3:0]  ra;
    logic        c;
    logic [3:0]  b;
    logic [3:0]  r;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [9:0]  rs;
    logic [7:0]  x;
    logic [6:0]  mag;
    logic [3:0]  vol;
    logic [30:0] q;
    logic        out_free;

    state_nxt     = state_r;
    ch_nxt        = ch_r;
    regs_nxt      = regs_r;
    inc_nxt       = inc_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    act_nxt       = act_r;
    bank_nxt      = bank_r;
    b0_nxt        = b0_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    end_nxt       = end_r;
    acc_nxt       = acc_r;
    rd_nxt        = rd_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    divisor_nxt   = divisor_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rd_nxt    = out_rd_r;
    out_smp_nxt   = out_smp_r;
    out_play_nxt  = out_play_r;
    ra            = in_ch.reg_address[3:0];
    c             = (in_ch.reg_address >= RegChan1);
    b             = ch_base(c);
    r             = ra - b;
    lo            = (r == RegPitchLo) ? in_ch.data : regs_r[b];
    hi            = (r == RegPitchHi) ? in_ch.data : regs_r[b + 4'd1];
    rs            = {rem_r, dvd_r[ScaleBits-1]};
    x             = {1'b0, b0_r[6:0]} - 8'd64;
    mag           = x[7] ? 7'(-x) : x[6:0];
    vol           = ch_r ? regs_r[RegVolume][3:0] : regs_r[RegVolume][7:4];
    q             = 31'((32'(prod_r) * 32'(Recip15)) >> Recip15Shift);
    out_free      = !out_valid_r || out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_OUT;
          rd_nxt    = 8'd0;
          acc_nxt   = 16'sd0;
          ch_nxt    = c;
          case (in_ch.cmd)
            CMD_WRITE: begin
              if (in_ch.reg_address < 8'(RegCount)) begin
                regs_nxt[ra] = in_ch.data;
                if (in_ch.reg_address < RegPerCh) begin
                  if (r == RegPitchLo || r == RegPitchHi) begin
                    divisor_nxt = 10'd512 - {1'b0, hi[0], lo};
                    dvd_nxt     = scale_r;
                    rem_nxt     = 9'd0;
                    cnt_nxt     = 5'd0;
                    state_nxt   = ST_DIV;
                  end else if (r == RegKeyOff) begin
                    start_nxt[c] = start_calc(regs_r[b + RegStart0], regs_r[b + RegStart1],
                                              regs_r[b + RegStart2], bank_r[c]);
                    pos_nxt[c]   = '0;
                    act_nxt[c]   = 1'b1;
                  end
                end
              end
            end
            CMD_READ: begin
              if (in_ch.reg_address < 8'(RegCount)) begin
                rd_nxt = regs_r[ra];
                if (in_ch.reg_address == RegKey0 || in_ch.reg_address == RegKey1) begin
                  start_nxt[c] = start_calc(regs_r[b + RegStart0], regs_r[b + RegStart1],
                                            regs_r[b + RegStart2], bank_r[c]);
                  pos_nxt[c]   = '0;
                  act_nxt[c]   = 1'b1;
                end
              end
            end
            CMD_TICK: begin
              ch_nxt    = 1'b0;
              state_nxt = ST_T_ADDR;
            end
            CMD_BANK: begin
              bank_nxt[in_ch.channel] = in_ch.bank;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (rs >= divisor_r) begin
          rem_nxt = 9'(rs - divisor_r);
          dvd_nxt = {dvd_r[ScaleBits-2:0], 1'b1};
        end else begin
          rem_nxt = rs[8:0];
          dvd_nxt = {dvd_r[ScaleBits-2:0], 1'b0};
        end
        if (cnt_r == 5'(DivSteps - 1)) begin
          inc_nxt[ch_r] = dvd_nxt;
          cnt_nxt       = 5'd0;
          state_nxt     = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_T_ADDR: begin
        if (act_r[ch_r]) begin
          state_nxt = ST_T_NEXT;
        end else if (ch_r) begin
          state_nxt = ST_OUT;
        end else begin
          ch_nxt = 1'b1;
        end
      end
      ST_T_NEXT: begin
        b0_nxt    = mem_q;
        state_nxt = ST_T_MUL;
      end
      ST_T_MUL: begin
        prod_nxt  = 11'(mag * vol);
        neg_nxt   = x[7];
        end_nxt   = b0_r[7] ||
                    ((inc_r[ch_r] >= (ScaleBits'(1) << FractionBits)) && mem_q[7]);
        state_nxt = ST_T_ACC;
      end
      ST_T_ACC: begin
        if (!mute_r[ch_r]) begin
          acc_nxt = neg_r ? acc_r - 16'(q) : acc_r + 16'(q);
        end
        pos_nxt[ch_r] = pos_r[ch_r] + PosBits'(inc_r[ch_r]);
        if (end_r) begin
          if (ch_r ? regs_r[RegLoop][1] : regs_r[RegLoop][0]) begin
            pos_nxt[ch_r]   = pos_nxt[ch_r] & ((PosBits'(1) << FractionBits) - PosBits'(1));
            start_nxt[ch_r] = start_calc(regs_r[ch_base(ch_r) + RegStart0],
                                         regs_r[ch_base(ch_r) + RegStart1],
                                         regs_r[ch_base(ch_r) + RegStart2], bank_r[ch_r]);
          end else begin
            act_nxt[ch_r] = 1'b0;
          end
        end
        if (ch_r) begin
          state_nxt = ST_OUT;
        end else begin
          ch_nxt    = 1'b1;
          state_nxt = ST_T_ADDR;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_smp_nxt   = acc_r;
          out_play_nxt  = act_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= 1'b0;
      regs_r      <= '{default: 8'd0};
      inc_r       <= '{default: '0};
      pos_r       <= '{default: '0};
      start_r     <= '{default: '0};
      act_r       <= 2'b00;
      bank_r      <= '{default: 2'd0};
      scale_r     <= ScaleBits'(19040000);
      mute_r      <= 2'b00;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      regs_r      <= regs_nxt;
      inc_r       <= inc_nxt;
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
      act_r       <= act_nxt;
      bank_r      <= bank_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CfgStepScale) begin
        scale_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CfgMuteMask) begin
        mute_r <= cfg_wdata[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    b0_r       <= b0_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    end_r      <= end_nxt;
    acc_r      <= acc_nxt;
    rd_r       <= rd_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    divisor_r  <= divisor_nxt;
    out_rd_r   <= out_rd_nxt;
    out_smp_r  <= out_smp_nxt;
    out_play_r <= out_play_nxt;
  end

  `ASSERT_CLK(a_div_cnt_idle, (state_r != ST_DIV) |-> (cnt_r == 5'd0))
  `ASSERT_CLK(a_play_match, (state_r == ST_OUT && state_nxt == ST_IDLE) |=> (out_play_r == act_r))
  `ASSERT_RST(a_reset_out, !rst_n |=> !out_valid_r)

endmodule
